// ===== src/ppw_pkg.sv =====
// ppw_pkg: shared types and constants of the winding-number point-in-polygon block.
// Used by ppw_mac, point_in_polygon_winding and ppw_chk; depends on nothing.
package ppw_pkg;

  // Defaults of the top-level parameters
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_WIDTH_DEF  = 32;

  // Fixed field widths of the ports
  localparam int FIELD_W  = 32;
  localparam int ACTION_W = 2;
  localparam int TOL_W    = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

  // Squared tolerance carries two Q0.16 fractions
  localparam int TOL_SQ_SHIFT = 2 * TOL_W;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TEST   = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOADD,
    ST_SETUP,
    ST_RDV,
    ST_LOADV,
    ST_VERT,
    ST_FIN
  } state_t;

  // Multiply-accumulate steps, in issue order
  typedef enum logic [4:0] {
    OP_NN0, OP_NN1, OP_NN2,
    OP_DD0, OP_DD1, OP_DD2,
    OP_ND0, OP_ND1, OP_ND2,
    OP_NDSQ, OP_NNDD, OP_T, OP_LIM,
    OP_YA0A, OP_YA0B, OP_YA1A, OP_YA1B, OP_YA2A, OP_YA2B,
    OP_X0, OP_X1, OP_X2,
    OP_Y0, OP_Y1, OP_Y2,
    OP_YY, OP_PYY, OP_CR0, OP_CR1
  } op_t;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic go;   // load operands and start
    logic clr;  // start from a zero accumulator
    logic sub;  // subtract the product
  } mac_ctl_t;

endpackage

// ===== src/ppw_ram.sv =====
// ppw_ram: generic single-write, single-read RAM with registered read data.
// Holds the vertex store; depends on nothing.
module ppw_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ppw_mac.sv =====
// ppw_mac: shared exact signed multiply-accumulate unit, one multiplier bit a cycle.
// Depends on ppw_pkg for the control struct.
module ppw_mac #(
  parameter int PW = 204,
  parameter int BW = 102
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ppw_pkg::mac_ctl_t    ctl,
  input  logic signed [PW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [PW-1:0] acc,
  output logic                 done
);

  logic                 run_r, run_nxt;
  logic signed [PW-1:0] acc_r, acc_nxt;
  logic signed [PW-1:0] mcand_r, mcand_nxt;
  logic [BW-1:0]        mplier_r, mplier_nxt;
  logic                 neg;
  logic [BW-1:0]        mag;

  // Fold the product sign into the multiplicand, iterate on the magnitude
  always_comb begin
    neg        = b[BW-1] ^ ctl.sub;
    mag        = b[BW-1] ? (~b + {{(BW-1){1'b0}}, 1'b1}) : b;
    run_nxt    = run_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    if (ctl.go) begin
      run_nxt    = 1'b1;
      mcand_nxt  = neg ? -a : a;
      mplier_nxt = mag;
      if (ctl.clr) begin
        acc_nxt = '0;
      end
    end else if (run_r) begin
      if (mplier_r == '0) begin
        run_nxt = 1'b0;
      end else begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = mcand_r <<< 1;
        mplier_nxt = mplier_r >> 1;
      end
    end
  end

  // Hold control under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign acc  = acc_r;
  assign done = run_r && (mplier_r == '0);

endmodule

// ===== src/point_in_polygon_winding.sv =====
// point_in_polygon_winding: winding-number point-in-polygon test over a stored 3D loop.
// Depends on ppw_pkg, ppw_ram (vertex store) and ppw_mac (shared multiply-accumulate).
// Clear and append finish in idle; an append result shows on the next cycle.
// A test runs its multiply-accumulate steps one at a time on the one shared unit:
// first a setup pass, then a pass per vertex of the loop.
// Reset (synchronous, active low) empties the loop and sets tolerance to 7; no result stalls.
module point_in_polygon_winding #(
  parameter int MAX_VERTICES = ppw_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = ppw_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [ppw_pkg::ACTION_W-1:0]        in_action,
  input  logic signed [ppw_pkg::FIELD_W-1:0]  in_coord_x,
  input  logic signed [ppw_pkg::FIELD_W-1:0]  in_coord_y,
  input  logic signed [ppw_pkg::FIELD_W-1:0]  in_coord_z,
  input  logic signed [ppw_pkg::FIELD_W-1:0]  in_normal_x,
  input  logic signed [ppw_pkg::FIELD_W-1:0]  in_normal_y,
  input  logic signed [ppw_pkg::FIELD_W-1:0]  in_normal_z,
  input  logic                                cfg_we,
  input  logic [ppw_pkg::TOL_W-1:0]           cfg_wdata,
  output logic                                out_valid,
  output logic                                out_inside_res,
  output logic                                out_not_coplanar,
  output logic                                out_overflow
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int XW   = 2 * DW + 2;
  localparam int YAW  = CW + DW + 1;
  localparam int YW   = DW + YAW + 2;
  localparam int PW   = 2 * YW + 2;
  localparam int BW   = YW + 1;
  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int SW   = CNTW + 3;
  localparam int VW   = 3 * CW;
  localparam logic signed [SW-1:0] ONE = SW'(1);
  localparam logic signed [SW-1:0] TWO = SW'(2);

  ppw_pkg::state_t       state_r, state_nxt;
  ppw_pkg::op_t          op_r, op_nxt;
  logic                  wait_r, wait_nxt;
  logic [CNTW-1:0]       count_r, count_nxt;
  logic [CNTW-1:0]       idx_r, idx_nxt;
  logic signed [SW-1:0]  sum_r, sum_nxt;
  logic                  pnear_r, pnear_nxt;
  logic                  ynear_r, ynear_nxt;
  logic [ppw_pkg::TOL_W-1:0] tol_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_inside_r, out_inside_nxt;
  logic                  out_ncop_r, out_ncop_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic signed [CW-1:0]  pt_r [3];
  logic signed [CW-1:0]  n_r [3];
  logic signed [DW-1:0]  d_r [3];
  logic signed [DW-1:0]  v_r [3];
  logic signed [YAW-1:0] yax_r [3];
  logic signed [XW-1:0]  nn_r, dd_r, x_r, px_r;
  logic signed [YW-1:0]  y_r, py_r;
  logic signed [PW-1:0]  nd2_r, lim_r, clim_r;

  logic                  cap_in, cap_d, cap_v, cap_nn, cap_dd, cap_nd2, cap_clim, cap_lim;
  logic                  cap_init, cap_x, cap_y, cap_prev, vert_end;
  logic [2:0]            cap_ya;

  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [VW-1:0]         ram_wdata, ram_rdata;
  logic signed [CW-1:0]  vert [3];

  ppw_pkg::mac_ctl_t     mac_ctl;
  logic                  mac_go, mac_clr, mac_sub, mac_done;
  logic signed [PW-1:0]  mac_a, mac_acc;
  logic signed [BW-1:0]  mac_b;

  // Vertex store, x in the low slice
  assign ram_wdata = {CW'($unsigned(in_coord_z)), CW'($unsigned(in_coord_y)),
                      CW'($unsigned(in_coord_x))};
  assign ram_raddr = (state_r == ppw_pkg::ST_RDV && idx_r != count_r) ? idx_r[AW-1:0] : '0;

  ppw_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vert[k] = $signed(ram_rdata[k*CW +: CW]);
    end
  end

  // Select operands of the current step
  always_comb begin
    mac_a   = '0;
    mac_b   = '0;
    mac_clr = 1'b0;
    mac_sub = 1'b0;
    case (op_r)
      ppw_pkg::OP_NN0:  begin mac_a = PW'(n_r[0]); mac_b = BW'(n_r[0]); mac_clr = 1'b1; end
      ppw_pkg::OP_NN1:  begin mac_a = PW'(n_r[1]); mac_b = BW'(n_r[1]); end
      ppw_pkg::OP_NN2:  begin mac_a = PW'(n_r[2]); mac_b = BW'(n_r[2]); end
      ppw_pkg::OP_DD0:  begin mac_a = PW'(d_r[0]); mac_b = BW'(d_r[0]); mac_clr = 1'b1; end
      ppw_pkg::OP_DD1:  begin mac_a = PW'(d_r[1]); mac_b = BW'(d_r[1]); end
      ppw_pkg::OP_DD2:  begin mac_a = PW'(d_r[2]); mac_b = BW'(d_r[2]); end
      ppw_pkg::OP_ND0:  begin mac_a = PW'(n_r[0]); mac_b = BW'(d_r[0]); mac_clr = 1'b1; end
      ppw_pkg::OP_ND1:  begin mac_a = PW'(n_r[1]); mac_b = BW'(d_r[1]); end
      ppw_pkg::OP_ND2:  begin mac_a = PW'(n_r[2]); mac_b = BW'(d_r[2]); end
      ppw_pkg::OP_NDSQ: begin mac_a = mac_acc; mac_b = BW'(mac_acc); mac_clr = 1'b1; end
      ppw_pkg::OP_NNDD: begin mac_a = PW'(nn_r); mac_b = BW'(dd_r); mac_clr = 1'b1; end
      ppw_pkg::OP_T:    begin mac_a = mac_acc; mac_b = BW'({1'b0, tol_r}); mac_clr = 1'b1; end
      ppw_pkg::OP_LIM:  begin mac_a = mac_acc; mac_b = BW'({1'b0, tol_r}); mac_clr = 1'b1; end
      ppw_pkg::OP_YA0A: begin mac_a = PW'(n_r[1]); mac_b = BW'(d_r[2]); mac_clr = 1'b1; end
      ppw_pkg::OP_YA0B: begin mac_a = PW'(n_r[2]); mac_b = BW'(d_r[1]); mac_sub = 1'b1; end
      ppw_pkg::OP_YA1A: begin mac_a = PW'(n_r[2]); mac_b = BW'(d_r[0]); mac_clr = 1'b1; end
      ppw_pkg::OP_YA1B: begin mac_a = PW'(n_r[0]); mac_b = BW'(d_r[2]); mac_sub = 1'b1; end
      ppw_pkg::OP_YA2A: begin mac_a = PW'(n_r[0]); mac_b = BW'(d_r[1]); mac_clr = 1'b1; end
      ppw_pkg::OP_YA2B: begin mac_a = PW'(n_r[1]); mac_b = BW'(d_r[0]); mac_sub = 1'b1; end
      ppw_pkg::OP_X0:   begin mac_a = PW'(v_r[0]); mac_b = BW'(d_r[0]); mac_clr = 1'b1; end
      ppw_pkg::OP_X1:   begin mac_a = PW'(v_r[1]); mac_b = BW'(d_r[1]); end
      ppw_pkg::OP_X2:   begin mac_a = PW'(v_r[2]); mac_b = BW'(d_r[2]); end
      ppw_pkg::OP_Y0:   begin mac_a = PW'(yax_r[0]); mac_b = BW'(v_r[0]); mac_clr = 1'b1; end
      ppw_pkg::OP_Y1:   begin mac_a = PW'(yax_r[1]); mac_b = BW'(v_r[1]); end
      ppw_pkg::OP_Y2:   begin mac_a = PW'(yax_r[2]); mac_b = BW'(v_r[2]); end
      ppw_pkg::OP_YY:   begin mac_a = PW'(y_r); mac_b = BW'(y_r); mac_clr = 1'b1; end
      ppw_pkg::OP_PYY:  begin mac_a = PW'(py_r); mac_b = BW'(y_r); mac_clr = 1'b1; end
      ppw_pkg::OP_CR0:  begin mac_a = PW'(x_r); mac_b = BW'(py_r); mac_clr = 1'b1; end
      ppw_pkg::OP_CR1:  begin mac_a = PW'(y_r); mac_b = BW'(px_r); mac_sub = 1'b1; end
      default: ;
    endcase
    mac_ctl.go  = mac_go;
    mac_ctl.clr = mac_clr;
    mac_ctl.sub = mac_sub;
  end

  ppw_mac #(.PW(PW), .BW(BW)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (mac_acc),
    .done  (mac_done)
  );

  // Sequence the actions and the test walk
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    wait_nxt       = wait_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    sum_nxt        = sum_r;
    pnear_nxt      = pnear_r;
    ynear_nxt      = ynear_r;
    out_valid_nxt  = 1'b0;
    out_inside_nxt = 1'b0;
    out_ncop_nxt   = 1'b0;
    out_ovf_nxt    = 1'b0;
    ram_we         = 1'b0;
    mac_go         = 1'b0;
    cap_in = 1'b0; cap_d = 1'b0; cap_v = 1'b0; cap_nn = 1'b0; cap_dd = 1'b0;
    cap_nd2 = 1'b0; cap_clim = 1'b0; cap_lim = 1'b0; cap_init = 1'b0;
    cap_x = 1'b0; cap_y = 1'b0; cap_prev = 1'b0; vert_end = 1'b0; cap_ya = '0;
    case (state_r)
      ppw_pkg::ST_IDLE: begin
        if (start) begin
          case (in_action)
            ppw_pkg::ACT_CLEAR: begin
              count_nxt = '0;
            end
            ppw_pkg::ACT_APPEND: begin
              out_valid_nxt = 1'b1;
              if (count_r == CNTW'(MAX_VERTICES)) begin
                out_ovf_nxt = 1'b1;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            ppw_pkg::ACT_TEST: begin
              cap_in = 1'b1;
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ppw_pkg::ST_LOADD;
              end
            end
            default: ;
          endcase
        end
      end
      ppw_pkg::ST_LOADD: begin
        cap_d     = 1'b1;
        state_nxt = ppw_pkg::ST_SETUP;
        op_nxt    = ppw_pkg::OP_NN0;
        wait_nxt  = 1'b0;
      end
      ppw_pkg::ST_SETUP, ppw_pkg::ST_VERT: begin
        if (!wait_r) begin
          mac_go   = 1'b1;
          wait_nxt = 1'b1;
        end else if (mac_done) begin
          wait_nxt = 1'b0;
          op_nxt   = ppw_pkg::op_t'(op_r + 1'b1);
          case (op_r)
            ppw_pkg::OP_NN2:  cap_nn   = 1'b1;
            ppw_pkg::OP_DD2:  cap_dd   = 1'b1;
            ppw_pkg::OP_NDSQ: cap_nd2  = 1'b1;
            ppw_pkg::OP_T:    cap_clim = 1'b1;
            ppw_pkg::OP_LIM: begin
              cap_lim = 1'b1;
              if (mac_acc < (nd2_r <<< ppw_pkg::TOL_SQ_SHIFT)) begin
                out_valid_nxt = 1'b1;
                out_ncop_nxt  = 1'b1;
                state_nxt     = ppw_pkg::ST_IDLE;
              end else begin
                pnear_nxt = (mac_acc > 0);
                cap_init  = 1'b1;
                sum_nxt   = '0;
              end
            end
            ppw_pkg::OP_YA0B: cap_ya[0] = 1'b1;
            ppw_pkg::OP_YA1B: cap_ya[1] = 1'b1;
            ppw_pkg::OP_YA2B: begin
              cap_ya[2] = 1'b1;
              idx_nxt   = CNTW'(1);
              state_nxt = ppw_pkg::ST_RDV;
            end
            ppw_pkg::OP_X2: cap_x = 1'b1;
            ppw_pkg::OP_Y2: cap_y = 1'b1;
            ppw_pkg::OP_YY: begin
              ynear_nxt = (mac_acc < lim_r);
              // Drop a vertex that stays on the axis line
              if ((mac_acc < lim_r) && pnear_r) begin
                vert_end = 1'b1;
              end
            end
            ppw_pkg::OP_PYY: begin
              if (!(mac_acc < clim_r)) begin
                // Touch of the positive axis
                if (pnear_r && px_r > 0) begin
                  sum_nxt = (y_r > 0) ? sum_r + ONE : sum_r - ONE;
                end else if (ynear_r && x_r > 0) begin
                  sum_nxt = (py_r < 0) ? sum_r + ONE : sum_r - ONE;
                end
                cap_prev = 1'b1;
                vert_end = 1'b1;
              end
            end
            ppw_pkg::OP_CR1: begin
              // Full crossing on the positive side
              if (mac_acc != '0 && py_r != '0 && mac_acc[PW-1] == py_r[YW-1]) begin
                sum_nxt = (py_r < 0) ? sum_r + TWO : sum_r - TWO;
              end
              cap_prev = 1'b1;
              vert_end = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ppw_pkg::ST_RDV: begin
        state_nxt = ppw_pkg::ST_LOADV;
      end
      ppw_pkg::ST_LOADV: begin
        cap_v     = 1'b1;
        state_nxt = ppw_pkg::ST_VERT;
        op_nxt    = ppw_pkg::OP_X0;
        wait_nxt  = 1'b0;
      end
      ppw_pkg::ST_FIN: begin
        out_valid_nxt  = 1'b1;
        out_inside_nxt = (sum_r != '0);
        state_nxt      = ppw_pkg::ST_IDLE;
      end
      default: state_nxt = ppw_pkg::ST_IDLE;
    endcase
    // Advance to the next vertex, closing the loop on the first one
    if (vert_end) begin
      if (idx_r == count_r) begin
        state_nxt = ppw_pkg::ST_FIN;
      end else begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ppw_pkg::ST_RDV;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppw_pkg::ST_IDLE;
      wait_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= ppw_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    sum_r        <= sum_nxt;
    pnear_r      <= pnear_nxt;
    ynear_r      <= ynear_nxt;
    out_inside_r <= out_inside_nxt;
    out_ncop_r   <= out_ncop_nxt;
    out_ovf_r    <= out_ovf_nxt;
    if (cap_in) begin
      pt_r[0] <= CW'($unsigned(in_coord_x));
      pt_r[1] <= CW'($unsigned(in_coord_y));
      pt_r[2] <= CW'($unsigned(in_coord_z));
      n_r[0]  <= CW'($unsigned(in_normal_x));
      n_r[1]  <= CW'($unsigned(in_normal_y));
      n_r[2]  <= CW'($unsigned(in_normal_z));
    end
    for (int k = 0; k < 3; k++) begin
      if (cap_d) begin
        d_r[k] <= DW'(vert[k]) - DW'(pt_r[k]);
      end
      if (cap_v) begin
        v_r[k] <= DW'(vert[k]) - DW'(pt_r[k]);
      end
      if (cap_ya[k]) begin
        yax_r[k] <= YAW'(mac_acc);
      end
    end
    if (cap_nn)   nn_r   <= XW'(mac_acc);
    if (cap_dd)   dd_r   <= XW'(mac_acc);
    if (cap_nd2)  nd2_r  <= mac_acc;
    if (cap_clim) clim_r <= -(mac_acc <<< ppw_pkg::TOL_W);
    if (cap_lim)  lim_r  <= mac_acc;
    if (cap_x)    x_r    <= XW'(mac_acc);
    if (cap_y)    y_r    <= YW'(mac_acc);
    if (cap_init) begin
      px_r <= dd_r;
      py_r <= '0;
    end else if (cap_prev) begin
      px_r    <= x_r;
      py_r    <= y_r;
      pnear_r <= ynear_r;
    end
  end

  assign busy             = (state_r != ppw_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_inside_res   = out_inside_r;
  assign out_not_coplanar = out_ncop_r;
  assign out_overflow     = out_ovf_r;

endmodule

// ===== src/ppw_chk.sv =====
// ppw_chk: port-level checks of the point-in-polygon block, bound to its top level.
// Depends on ppw_pkg for the action codes.
module ppw_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [ppw_pkg::ACTION_W-1:0] in_action,
  input logic                         out_valid,
  input logic                         out_inside_res,
  input logic                         out_not_coplanar,
  input logic                         out_overflow
);

  // An off-plane point is never reported inside
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_inside_res && out_not_coplanar))
    else $error("inside and not_coplanar both set");

  // An overflowing append result carries no test flags
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (!out_inside_res && !out_not_coplanar))
    else $error("overflow with test flags");

  // An append answers on the next cycle and leaves the block free
  a_app: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == ppw_pkg::ACT_APPEND) |=> (out_valid && !busy))
    else $error("append result missing");

  // A clear gives no result
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == ppw_pkg::ACT_CLEAR) |=> !out_valid)
    else $error("clear produced a result");

  // A test either answers at once or keeps the block busy
  a_tst: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == ppw_pkg::ACT_TEST) |=> (busy != out_valid))
    else $error("test neither answered nor started");

endmodule

bind point_in_polygon_winding ppw_chk u_ppw_chk (.*);
